// ----- rtl/tfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg: shared types and constants of the traffic flow counter
// Item formats, controller commands, datapath status and the protocol slot map.
// ----------------------------------------------------------------------------
package tfc_pkg;

    // The pair index is taken from the hash by a bit mask, so the table depth
    // is kept a power of two.
    localparam int PAIR_ENTRIES = 1024;
    localparam int PROTO_SLOTS  = 10;
    localparam int IDX_W        = $clog2(PAIR_ENTRIES);
    localparam int PROTO_W      = $clog2(PROTO_SLOTS);
    localparam int OCC_W        = $clog2(PAIR_ENTRIES + 1);
    localparam int KNOWN_CODES  = 10;
    localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;
    localparam int HASH_SHIFT   = 16;

    localparam logic [1:0] OP_COUNT      = 2'd0;
    localparam logic [1:0] OP_READ_PROTO = 2'd1;
    localparam logic [1:0] OP_READ_PAIR  = 2'd2;
    localparam logic [1:0] OP_NOP        = 2'd3;

    localparam logic [3:0] NET_IPV4 = 4'd1;

    localparam logic [1:0] PST_NONE     = 2'd0;
    localparam logic [1:0] PST_EXIST    = 2'd1;
    localparam logic [1:0] PST_NEW      = 2'd2;
    localparam logic [1:0] PST_FALLBACK = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] pkt_length;
        logic [3:0]  net_proto;
        logic [3:0]  trans_proto;
        logic [3:0]  app_code;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [9:0]  read_index;
    } req_t;

    typedef struct packed {
        logic [63:0] total_pkts;
        logic [63:0] total_octets;
        logic [1:0]  pair_status;
        logic [9:0]  pair_slot;
        logic [31:0] pair_src;
        logic [31:0] pair_dst;
        logic [63:0] pair_pkts;
        logic [63:0] pair_octets;
        logic [63:0] proto_pkts;
        logic [63:0] proto_octets;
        logic [10:0] pairs_used;
    } rsp_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [63:0] pkts;
        logic [63:0] octs;
    } pair_entry_t;

    typedef struct packed {
        logic [63:0] pkts;
        logic [63:0] octs;
    } proto_entry_t;

    typedef struct packed {
        logic clr;
        logic load_item;
        logic proto_rd;
        logic proto_wr;
        logic hash1;
        logic hash2;
        logic hash3;
        logic probe_rd;
        logic probe_adv;
        logic new_wr;
        logic hit_wr;
        logic fb_rd;
        logic fb_wr;
        logic read_proto;
        logic read_pair;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic [1:0] op;
        logic       ipv4;
        logic       job_more;
        logic       table_full;
        logic       slot_empty;
        logic       slot_match;
        logic       probes_last;
        logic       out_free;
    } stat_t;

    function automatic logic [PROTO_W-1:0] proto_slot(input logic [3:0] code);
        logic [PROTO_W-1:0] slot;
        slot = '0;
        if ((32'(code) < KNOWN_CODES) && (32'(code) < PROTO_SLOTS))
        begin
            slot = code[PROTO_W-1:0];
        end
        return slot;
    endfunction

endpackage

// ----- rtl/tfc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tfc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_ctrl: sequencer of the traffic flow counter
// Steps each item through protocol updates, hashing, probing and output.
// ----------------------------------------------------------------------------
module tfc_ctrl
    import tfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_PROTO_RD = 13'b0000000001000,
        S_PROTO_WR = 13'b0000000010000,
        S_HASH1    = 13'b0000000100000,
        S_HASH2    = 13'b0000001000000,
        S_HASH3    = 13'b0000010000000,
        S_PROBE_RD = 13'b0000100000000,
        S_PROBE_CHK= 13'b0001000000000,
        S_FB_RD    = 13'b0010000000000,
        S_FB_WR    = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_COUNT:      state_next = S_PROTO_RD;
                    OP_READ_PROTO:
                    begin
                        cmd.read_proto = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_READ_PAIR:
                    begin
                        cmd.read_pair = 1'b1;
                        state_next = S_DONE;
                    end
                    default:       state_next = S_DONE;
                endcase
            end
            S_PROTO_RD:
            begin
                cmd.proto_rd = 1'b1;
                state_next = S_PROTO_WR;
            end
            S_PROTO_WR:
            begin
                cmd.proto_wr = 1'b1;
                if (stat.job_more)
                begin
                    state_next = S_PROTO_RD;
                end
                else if (stat.ipv4)
                begin
                    state_next = S_HASH1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_HASH1:
            begin
                cmd.hash1 = 1'b1;
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                cmd.hash2 = 1'b1;
                state_next = S_HASH3;
            end
            S_HASH3:
            begin
                cmd.hash3 = 1'b1;
                state_next = stat.table_full ? S_FB_RD : S_PROBE_RD;
            end
            S_PROBE_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (stat.slot_empty)
                begin
                    cmd.new_wr = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.slot_match)
                begin
                    cmd.hit_wr = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.probes_last)
                begin
                    state_next = S_FB_RD;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_FB_RD:
            begin
                cmd.fb_rd = 1'b1;
                state_next = S_FB_WR;
            end
            S_FB_WR:
            begin
                cmd.fb_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // A slot is only judged on the data of the read issued just before.
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_CHK) |-> $past(state_reg == S_PROBE_RD))
        else $error("probe check without a preceding probe read");

    // The fallback update uses the read of slot zero from the cycle before.
    a_fb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fb_wr |-> $past(cmd.fb_rd))
        else $error("fallback write without a slot zero read");

    // Items are taken only once the clearing pass has finished.
    a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> $past(state_reg != S_CLEAR) || $past(stat.clear_done))
        else $error("item accepted during the clearing pass");

endmodule

// ----- rtl/tfc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_datapath: counters, hash unit and table memories
// Holds the totals, the protocol and pair memories and the result register.
// ----------------------------------------------------------------------------
module tfc_datapath
    import tfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req_data,
    input  cmd_t  cmd,
    output stat_t stat,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp_data
);

    req_t               item_reg;
    logic [63:0]        pkt_total_reg;
    logic [63:0]        oct_total_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [3:0]         job_reg;
    logic [31:0]        hk_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [IDX_W-1:0]   pcnt_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [1:0]         res_status_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    pair_entry_t        res_entry_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    logic [63:0]        len64;
    logic [PROTO_W-1:0] cur_slot;
    logic [3:0]         job_low;
    logic [31:0]        hash_in;
    logic [31:0]        hash_mix;
    logic [31:0]        hash_prod;
    logic [31:0]        hash_fin;

    logic               pr_we, pr_re;
    logic [PROTO_W-1:0] pr_waddr, pr_raddr;
    proto_entry_t       pr_wdata, pr_rdata;
    logic               pa_we, pa_re;
    logic [IDX_W-1:0]   pa_waddr, pa_raddr;
    pair_entry_t        pa_wdata, pa_rdata;

    rsp_t               rsp_next;

    assign len64 = {48'd0, item_reg.pkt_length};

    // The lowest pending protocol update is served first.
    always_comb
    begin
        if (job_reg[0])
        begin
            cur_slot = proto_slot(item_reg.net_proto);
        end
        else if (job_reg[1])
        begin
            cur_slot = proto_slot(item_reg.trans_proto);
        end
        else if (job_reg[2])
        begin
            cur_slot = proto_slot(item_reg.app_code);
        end
        else
        begin
            cur_slot = '0;
        end
    end
    assign job_low = job_reg & (~job_reg + 4'd1);

    // Only the low 32 bits of each hash product are kept.
    assign hash_in   = cmd.hash1 ? (item_reg.src_addr ^ item_reg.dst_addr) : hk_reg;
    assign hash_mix  = hash_in ^ (hash_in >> HASH_SHIFT);
    assign hash_prod = hash_mix * HASH_MUL;
    assign hash_fin  = hk_reg ^ (hk_reg >> HASH_SHIFT);

    // Protocol memory ports.
    always_comb
    begin
        pr_re    = cmd.proto_rd ||
                   (cmd.read_proto && (32'(item_reg.read_index) < PROTO_SLOTS));
        pr_raddr = cmd.read_proto ? item_reg.read_index[PROTO_W-1:0] : cur_slot;
        pr_we    = (cmd.clr && (32'(clr_reg) < PROTO_SLOTS)) || cmd.proto_wr;
        pr_waddr = cmd.clr ? clr_reg[PROTO_W-1:0] : cur_slot;
        pr_wdata = '0;
        if (!cmd.clr)
        begin
            pr_wdata.pkts = pr_rdata.pkts + 64'd1;
            pr_wdata.octs = pr_rdata.octs + len64;
        end
    end

    // Pair memory ports.
    always_comb
    begin
        pa_re = cmd.probe_rd || cmd.read_pair || cmd.fb_rd;
        if (cmd.read_pair)
        begin
            pa_raddr = item_reg.read_index[IDX_W-1:0];
        end
        else if (cmd.fb_rd)
        begin
            pa_raddr = '0;
        end
        else
        begin
            pa_raddr = pidx_reg;
        end
        pa_we = cmd.clr || cmd.new_wr || cmd.hit_wr || cmd.fb_wr;
        if (cmd.clr)
        begin
            pa_waddr = clr_reg;
        end
        else if (cmd.fb_wr)
        begin
            pa_waddr = '0;
        end
        else
        begin
            pa_waddr = pidx_reg;
        end
        pa_wdata = '0;
        if (cmd.new_wr)
        begin
            pa_wdata.src  = item_reg.src_addr;
            pa_wdata.dst  = item_reg.dst_addr;
            pa_wdata.pkts = 64'd1;
            pa_wdata.octs = len64;
        end
        else if (!cmd.clr)
        begin
            pa_wdata.src  = pa_rdata.src;
            pa_wdata.dst  = pa_rdata.dst;
            pa_wdata.pkts = pa_rdata.pkts + 64'd1;
            pa_wdata.octs = pa_rdata.octs + len64;
        end
    end

    tfc_ram #(.WIDTH($bits(proto_entry_t)), .DEPTH(PROTO_SLOTS)) u_proto_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .re    (pr_re),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    tfc_ram #(.WIDTH($bits(pair_entry_t)), .DEPTH(PAIR_ENTRIES)) u_pair_ram (
        .clk   (clk),
        .we    (pa_we),
        .waddr (pa_waddr),
        .wdata (pa_wdata),
        .re    (pa_re),
        .raddr (pa_raddr),
        .rdata (pa_rdata)
    );

    // Result assembly.
    always_comb
    begin
        rsp_next = '0;
        rsp_next.total_pkts   = pkt_total_reg;
        rsp_next.total_octets = oct_total_reg;
        rsp_next.pairs_used   = occ_reg;
        case (item_reg.operation)
            OP_COUNT:
            begin
                rsp_next.pair_status = res_status_reg;
                rsp_next.pair_slot   = res_slot_reg;
                rsp_next.pair_src    = res_entry_reg.src;
                rsp_next.pair_dst    = res_entry_reg.dst;
                rsp_next.pair_pkts   = res_entry_reg.pkts;
                rsp_next.pair_octets = res_entry_reg.octs;
            end
            OP_READ_PROTO:
            begin
                if (32'(item_reg.read_index) < PROTO_SLOTS)
                begin
                    rsp_next.proto_pkts   = pr_rdata.pkts;
                    rsp_next.proto_octets = pr_rdata.octs;
                end
            end
            OP_READ_PAIR:
            begin
                rsp_next.pair_slot = item_reg.read_index;
                if (32'(item_reg.read_index) < PAIR_ENTRIES)
                begin
                    rsp_next.pair_src    = pa_rdata.src;
                    rsp_next.pair_dst    = pa_rdata.dst;
                    rsp_next.pair_pkts   = pa_rdata.pkts;
                    rsp_next.pair_octets = pa_rdata.octs;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_total_reg <= '0;
            oct_total_reg <= '0;
            occ_reg       <= '0;
            job_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.load_item)
            begin
                if (req_data.operation == OP_COUNT)
                begin
                    pkt_total_reg <= pkt_total_reg + 64'd1;
                    oct_total_reg <= oct_total_reg + {48'd0, req_data.pkt_length};
                    job_reg <= {(req_data.net_proto == 4'd0) &&
                                    (req_data.trans_proto == 4'd0),
                                req_data.app_code != 4'd0,
                                req_data.trans_proto != 4'd0,
                                req_data.net_proto != 4'd0};
                end
                else
                begin
                    job_reg <= '0;
                end
            end
            if (cmd.proto_wr)
            begin
                job_reg <= job_reg & ~job_low;
            end
            if (cmd.new_wr)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg       <= req_data;
            res_status_reg <= PST_NONE;
            res_slot_reg   <= '0;
            res_entry_reg  <= '0;
        end
        if (cmd.hash1 || cmd.hash2)
        begin
            hk_reg <= hash_prod;
        end
        if (cmd.hash3)
        begin
            pidx_reg <= hash_fin[IDX_W-1:0];
            pcnt_reg <= '0;
        end
        if (cmd.probe_adv)
        begin
            pidx_reg <= pidx_reg + IDX_W'(1);
            pcnt_reg <= pcnt_reg + IDX_W'(1);
        end
        if (cmd.new_wr || cmd.hit_wr || cmd.fb_wr)
        begin
            res_status_reg <= cmd.new_wr ? PST_NEW : (cmd.hit_wr ? PST_EXIST : PST_FALLBACK);
            res_slot_reg   <= pa_waddr;
            res_entry_reg  <= pa_wdata;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        stat.clear_done  = (clr_reg == IDX_W'(PAIR_ENTRIES - 1));
        stat.op          = item_reg.operation;
        stat.ipv4        = (item_reg.net_proto == NET_IPV4);
        stat.job_more    = (job_reg & ~job_low) != 4'd0;
        stat.table_full  = (32'(occ_reg) >= PAIR_ENTRIES);
        stat.slot_empty  = (pa_rdata.pkts == 64'd0);
        stat.slot_match  = ((pa_rdata.src == item_reg.src_addr) &&
                            (pa_rdata.dst == item_reg.dst_addr)) ||
                           ((pa_rdata.src == item_reg.dst_addr) &&
                            (pa_rdata.dst == item_reg.src_addr));
        stat.probes_last = (pcnt_reg == IDX_W'(PAIR_ENTRIES - 1));
        stat.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // A new pair is only created while the table has room.
    a_new_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.new_wr |-> (32'(occ_reg) < PAIR_ENTRIES))
        else $error("new pair written into a full table");

    // The result register is never overwritten while a result waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("pending result overwritten");

    // The occupancy count moves only by a new pair.
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.new_wr |=> $stable(occ_reg))
        else $error("occupancy changed without a new pair");

endmodule

// ----- rtl/traffic_flow_counter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_flow_counter_top: packet and flow statistics counter
// Counts packet descriptors in total, protocol and address pair counters.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 1024 pair entries and the
// protocol memory and holds req_stall high meanwhile. It then works on one item
// at a time and takes no new item before the last one is through. A read or
// no-operation item passes through dispatch and output. A count item adds a
// read-modify-write pass on the protocol memory for each protocol counter it
// updates (one to three passes); an IPv4 count item then adds the hashing steps
// and probes of the pair memory, each a read and a check of one slot. A walk
// over the whole table ends after 1024 probes and the fallback to slot 0 then
// adds a read and a write, while an item that finds the table already full
// takes the fallback in place of the first probe. The controller returns to
// idle as the result is loaded, and the next item can be accepted from there.
// The result is held in an output register, so the next item is accepted while
// the last result still waits to be taken.
// ----------------------------------------------------------------------------
module traffic_flow_counter_top
    import tfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences each item through the datapath steps.
    tfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath owns all counters, the hash unit and the memories.
    tfc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
